### rtl/teq_pkg.sv
// Shared types, codes and constants of the timed event queue.
package teq_pkg;

    localparam int QueueDepthDefault = 32;
    localparam int MaxFire           = 32;
    localparam int FireW             = $clog2(MaxFire);

    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_CANCEL   = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;
    localparam logic [1:0] OP_SERVICE  = 2'd3;

    localparam logic [2:0] CMD_HOLD    = 3'd0;
    localparam logic [2:0] CMD_INSERT  = 3'd1;
    localparam logic [2:0] CMD_CANCEL  = 3'd2;
    localparam logic [2:0] CMD_COMPACT = 3'd3;
    localparam logic [2:0] CMD_SHIFT   = 3'd4;

    typedef struct packed {
        logic        occ;
        logic [31:0] due;
        logic [15:0] owner;
        logic [11:0] kind;
        logic [15:0] tag;
    } t_entry;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] due;
        logic [15:0] owner;
        logic [11:0] kind;
        logic [15:0] tag;
        logic        any;
    } t_cell_ctl;

    typedef struct packed {
        logic        fired_valid;
        logic [15:0] fired_owner;
        logic [11:0] fired_kind;
        logic [15:0] fired_tag;
        logic [31:0] fired_due;
        logic        is_pending;
        logic        full_error;
        logic        last;
    } t_result;

endpackage

### rtl/timed_event_queue.sv
// Top level of the timed event queue: cell row and command sequencing.
//
// Entries sit in a row of QUEUE_DEPTH cells sorted by due time, head at cell 0.
// A schedule or a query is taken while idle and its single word appears on the
// next cycle; busy stays low. A cancel clears matching cells at once, then
// closes the gaps by moving entries one cell left per cycle; busy holds and
// the single word comes out when the row is dense again. A service first
// latches i_now, then pops one due entry from the head per cycle, at most
// MaxFire per item, or gives one empty word when nothing is due; busy drops
// in the cycle in which the word with o_last is on the ports. Words leave on
// o_strobe for one cycle each and must be taken as they come.
module timed_event_queue #(
    parameter int QUEUE_DEPTH = teq_pkg::QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_now,
    input  logic [15:0] i_owner_id,
    input  logic [11:0] i_event_kind,
    input  logic        i_any_kind,
    input  logic [30:0] i_delay,
    input  logic [15:0] i_payload_tag,
    output logic        o_strobe,
    output logic        o_fired_valid,
    output logic [15:0] o_fired_owner,
    output logic [11:0] o_fired_kind,
    output logic [15:0] o_fired_tag,
    output logic [31:0] o_fired_due,
    output logic        o_is_pending,
    output logic        o_full_error,
    output logic        o_last
);
    import teq_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_CANCEL  = 2'd1;
    localparam logic [1:0] ST_SERVICE = 2'd2;

    t_entry                 ent   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] after;
    logic [QUEUE_DEPTH-1:0] match;
    logic [QUEUE_DEPTH-1:0] bubble;
    t_cell_ctl              ctl;

    logic [1:0]       r_state, n_state;
    logic [31:0]      r_now, n_now;
    logic [FireW-1:0] r_cnt, n_cnt;
    logic             r_strobe, n_strobe;
    t_result          r_res, n_res;

    logic accept;
    logic full;
    logic head_due;
    logic next_due;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_entry left_ent;
            t_entry right_ent;
            logic   left_after;
            logic   left_empty;
            if (g == 0) begin : g_head
                assign left_ent   = '0;
                assign left_after = 1'b1;
                assign left_empty = 1'b0;
            end else begin : g_body
                assign left_ent   = ent[g-1];
                assign left_after = after[g-1];
                assign left_empty = !ent[g-1].occ;
            end
            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign right_ent = '0;
            end else begin : g_mid
                assign right_ent = ent[g+1];
            end
            teq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_left       (left_ent),
                .i_left_after (left_after),
                .i_left_empty (left_empty),
                .i_right      (right_ent),
                .o_ent        (ent[g]),
                .o_after      (after[g]),
                .o_match      (match[g]),
                .o_bubble     (bubble[g])
            );
        end
    endgenerate

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign full     = ent[QUEUE_DEPTH-1].occ;
    assign head_due = ent[0].occ && (ent[0].due <= r_now);
    assign next_due = ent[1].occ && (ent[1].due <= r_now);

    always_comb begin
        ctl.cmd   = CMD_HOLD;
        ctl.due   = i_now + {1'b0, i_delay};
        ctl.owner = i_owner_id;
        ctl.kind  = i_event_kind;
        ctl.tag   = i_payload_tag;
        ctl.any   = i_any_kind;
        n_state   = r_state;
        n_now     = r_now;
        n_cnt     = r_cnt;
        n_strobe  = 1'b0;
        n_res     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        OP_SCHEDULE: begin
                            n_strobe = 1'b1;
                            n_res.last = 1'b1;
                            if (full) begin
                                n_res.full_error = 1'b1;
                            end else begin
                                ctl.cmd = CMD_INSERT;
                            end
                        end
                        OP_CANCEL: begin
                            ctl.cmd = CMD_CANCEL;
                            n_state = ST_CANCEL;
                        end
                        OP_QUERY: begin
                            n_strobe = 1'b1;
                            n_res.is_pending = |match;
                            n_res.last = 1'b1;
                        end
                        OP_SERVICE: begin
                            n_now   = i_now;
                            n_cnt   = '0;
                            n_state = ST_SERVICE;
                        end
                    endcase
                end
            end
            ST_CANCEL: begin
                if (|bubble) begin
                    ctl.cmd = CMD_COMPACT;
                end else begin
                    n_strobe   = 1'b1;
                    n_res.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_SERVICE: begin
                n_strobe = 1'b1;
                if (head_due) begin
                    ctl.cmd           = CMD_SHIFT;
                    n_res.fired_valid = 1'b1;
                    n_res.fired_owner = ent[0].owner;
                    n_res.fired_kind  = ent[0].kind;
                    n_res.fired_tag   = ent[0].tag;
                    n_res.fired_due   = ent[0].due;
                    n_res.last        = !next_due || (r_cnt == FireW'(MaxFire - 1));
                    n_cnt             = r_cnt + 1'b1;
                    if (n_res.last) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_res.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now <= n_now;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

    assign o_strobe      = r_strobe;
    assign o_fired_valid = r_res.fired_valid;
    assign o_fired_owner = r_res.fired_owner;
    assign o_fired_kind  = r_res.fired_kind;
    assign o_fired_tag   = r_res.fired_tag;
    assign o_fired_due   = r_res.fired_due;
    assign o_is_pending  = r_res.is_pending;
    assign o_full_error  = r_res.full_error;
    assign o_last        = r_res.last;

endmodule

### rtl/teq_cell.sv
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
module teq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  teq_pkg::t_cell_ctl i_ctl,
    input  teq_pkg::t_entry    i_left,
    input  logic               i_left_after,
    input  logic               i_left_empty,
    input  teq_pkg::t_entry    i_right,
    output teq_pkg::t_entry    o_ent,
    output logic               o_after,
    output logic               o_match,
    output logic               o_bubble
);
    import teq_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    t_entry new_ent;
    logic   hit;

    assign new_ent  = '{occ: 1'b1, due: i_ctl.due, owner: i_ctl.owner,
                        kind: i_ctl.kind, tag: i_ctl.tag};
    assign o_after  = r_ent.occ && (i_ctl.due >= r_ent.due);
    assign o_match  = r_ent.occ && (r_ent.owner == i_ctl.owner)
                      && (r_ent.kind == i_ctl.kind);
    assign hit      = r_ent.occ && (r_ent.owner == i_ctl.owner)
                      && (i_ctl.any || (r_ent.kind == i_ctl.kind));
    assign o_bubble = !r_ent.occ && i_right.occ;
    assign o_ent    = r_ent;

    always_comb begin
        n_ent = r_ent;
        unique case (i_ctl.cmd)
            CMD_INSERT: begin
                if (!o_after) begin
                    n_ent = i_left_after ? new_ent : i_left;
                end
            end
            CMD_CANCEL: begin
                if (hit) begin
                    n_ent.occ = 1'b0;
                end
            end
            CMD_COMPACT: begin
                if (!r_ent.occ) begin
                    n_ent = i_right;
                end else if (i_left_empty) begin
                    n_ent.occ = 1'b0;
                end
            end
            CMD_SHIFT: begin
                n_ent = i_right;
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent.due   <= n_ent.due;
        r_ent.owner <= n_ent.owner;
        r_ent.kind  <= n_ent.kind;
        r_ent.tag   <= n_ent.tag;
        if (!i_rst_n) begin
            r_ent.occ <= 1'b0;
        end else begin
            r_ent.occ <= n_ent.occ;
        end
    end

endmodule

### tb/teq_checker.sv
// Checker for the timed event queue: mirrors the entry row and checks every output word.
module teq_checker #(
    parameter int QUEUE_DEPTH = teq_pkg::QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_now,
    input  logic [15:0] i_owner_id,
    input  logic [11:0] i_event_kind,
    input  logic        i_any_kind,
    input  logic [30:0] i_delay,
    input  logic [15:0] i_payload_tag,
    input  logic        o_strobe,
    input  logic        o_fired_valid,
    input  logic [15:0] o_fired_owner,
    input  logic [11:0] o_fired_kind,
    input  logic [15:0] o_fired_tag,
    input  logic [31:0] o_fired_due,
    input  logic        o_is_pending,
    input  logic        o_full_error,
    input  logic        o_last,
    output int          o_fail_count,
    output int          o_words_awaited
);
    timeunit 1ns;
    timeprecision 1ps;
    import teq_pkg::*;

    typedef struct packed {
        logic [31:0] due;
        logic [15:0] owner;
        logic [11:0] kind;
        logic [15:0] tag;
    } t_slot;

    t_slot   shadow_row [QUEUE_DEPTH];
    int      shadow_count = 0;
    t_result awaited_words [$];
    int      mismatches = 0;
    int      awaited_now = 0;

    assign o_fail_count    = mismatches;
    assign o_words_awaited = awaited_now;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic mirror_command(input logic [1:0] op, input logic [31:0] now,
                                  input logic [15:0] owner, input logic [11:0] kind,
                                  input logic any, input logic [30:0] delay,
                                  input logic [15:0] tag);
        t_result word;
        t_slot   fresh;
        int      pos;
        int      i;
        int      kept;
        int      fire_n;
        logic    found;
        word = '0;
        case (op)
            OP_SCHEDULE: begin
                word.last = 1'b1;
                if (shadow_count >= QUEUE_DEPTH) begin
                    word.full_error = 1'b1;
                end else begin
                    fresh.due   = now + {1'b0, delay};
                    fresh.owner = owner;
                    fresh.kind  = kind;
                    fresh.tag   = tag;
                    pos = 0;
                    while (pos < shadow_count && fresh.due >= shadow_row[pos].due) pos++;
                    for (i = shadow_count; i > pos; i--) shadow_row[i] = shadow_row[i-1];
                    shadow_row[pos] = fresh;
                    shadow_count++;
                end
                awaited_words.push_back(word);
            end
            OP_CANCEL: begin
                kept = 0;
                for (i = 0; i < shadow_count; i++) begin
                    if (!(shadow_row[i].owner == owner && (any || shadow_row[i].kind == kind))) begin
                        shadow_row[kept] = shadow_row[i];
                        kept++;
                    end
                end
                shadow_count = kept;
                word.last = 1'b1;
                awaited_words.push_back(word);
            end
            OP_QUERY: begin
                found = 1'b0;
                for (i = 0; i < shadow_count; i++) begin
                    if (shadow_row[i].owner == owner && shadow_row[i].kind == kind) found = 1'b1;
                end
                word.is_pending = found;
                word.last       = 1'b1;
                awaited_words.push_back(word);
            end
            default: begin
                fire_n = 0;
                while (fire_n < MaxFire && fire_n < shadow_count
                       && shadow_row[fire_n].due <= now) fire_n++;
                if (fire_n == 0) begin
                    word.last = 1'b1;
                    awaited_words.push_back(word);
                end
                for (i = 0; i < fire_n; i++) begin
                    word = '0;
                    word.fired_valid = 1'b1;
                    word.fired_owner = shadow_row[i].owner;
                    word.fired_kind  = shadow_row[i].kind;
                    word.fired_tag   = shadow_row[i].tag;
                    word.fired_due   = shadow_row[i].due;
                    word.last        = (i == fire_n - 1);
                    awaited_words.push_back(word);
                end
                for (i = fire_n; i < shadow_count; i++) shadow_row[i-fire_n] = shadow_row[i];
                shadow_count -= fire_n;
            end
        endcase
    endtask

    task automatic check_word();
        t_result want;
        want = awaited_words.pop_front();
        if (o_fired_valid !== want.fired_valid)
            report_mismatch("fired_valid", 32'(o_fired_valid), 32'(want.fired_valid));
        if (o_fired_owner !== want.fired_owner)
            report_mismatch("fired_owner", 32'(o_fired_owner), 32'(want.fired_owner));
        if (o_fired_kind !== want.fired_kind)
            report_mismatch("fired_kind", 32'(o_fired_kind), 32'(want.fired_kind));
        if (o_fired_tag !== want.fired_tag)
            report_mismatch("fired_tag", 32'(o_fired_tag), 32'(want.fired_tag));
        if (o_fired_due !== want.fired_due)
            report_mismatch("fired_due", o_fired_due, want.fired_due);
        if (o_is_pending !== want.is_pending)
            report_mismatch("is_pending", 32'(o_is_pending), 32'(want.is_pending));
        if (o_full_error !== want.full_error)
            report_mismatch("full_error", 32'(o_full_error), 32'(want.full_error));
        if (o_last !== want.last)
            report_mismatch("last", 32'(o_last), 32'(want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            awaited_words.delete();
        end else begin
            if (o_strobe === 1'b1) begin
                if (awaited_words.size() == 0)
                    report_mismatch("word with nothing awaited, fired_due", o_fired_due, 32'd0);
                else
                    check_word();
            end
            if (start && busy === 1'b0)
                mirror_command(i_op, i_now, i_owner_id, i_event_kind, i_any_kind,
                               i_delay, i_payload_tag);
        end
        awaited_now = awaited_words.size();
    end

endmodule

### tb/timed_event_queue_tb.sv
// Testbench top for the timed event queue: clock, reset, command stimulus and verdict.
module timed_event_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import teq_pkg::*;

    localparam int Depth      = QueueDepthDefault;
    localparam int RandomWords = 350;
    localparam int CalmTail   = 300;
    localparam int CycleLimit = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_op = OP_QUERY;
    logic [31:0] i_now = '0;
    logic [15:0] i_owner_id = '0;
    logic [11:0] i_event_kind = '0;
    logic        i_any_kind = 1'b0;
    logic [30:0] i_delay = '0;
    logic [15:0] i_payload_tag = '0;
    logic        o_strobe;
    logic        o_fired_valid;
    logic [15:0] o_fired_owner;
    logic [11:0] o_fired_kind;
    logic [15:0] o_fired_tag;
    logic [31:0] o_fired_due;
    logic        o_is_pending;
    logic        o_full_error;
    logic        o_last;
    int          fail_count;
    int          words_awaited;

    int          cycle_count = 0;
    int          words_sent = 0;
    logic        gaps_on = 1'b0;
    logic [31:0] clock_ms;

    timed_event_queue #(.QUEUE_DEPTH(Depth)) dut (.*);

    teq_checker #(.QUEUE_DEPTH(Depth)) u_check (
        .*,
        .o_fail_count   (fail_count),
        .o_words_awaited(words_awaited)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [31:0] now,
                             input logic [15:0] owner, input logic [11:0] kind,
                             input logic any, input logic [30:0] delay,
                             input logic [15:0] tag);
        logic taken;
        if (gaps_on && words_sent < CalmTail && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_op          <= op;
        i_now         <= now;
        i_owner_id    <= owner;
        i_event_kind  <= kind;
        i_any_kind    <= any;
        i_delay       <= delay;
        i_payload_tag <= tag;
        start         <= 1'b1;
        do begin
            @(negedge i_clk);
            taken = (busy === 1'b0);
            @(posedge i_clk);
        end while (!taken);
        words_sent++;
    endtask

    function automatic logic [15:0] pick_owner();
        return ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    endfunction

    function automatic logic [11:0] pick_kind();
        return ($urandom_range(0, 99) < 85) ? 12'($urandom_range(0, 3)) : 12'($urandom);
    endfunction

    function automatic logic [30:0] pick_delay();
        return ($urandom_range(0, 99) < 88) ? 31'($urandom_range(0, 40)) : 31'($urandom);
    endfunction

    // fill past capacity, then drain everything at the latest time
    task automatic flood_queue();
        repeat (Depth + 2)
            send_word(OP_SCHEDULE, clock_ms, pick_owner(), pick_kind(), 1'($urandom),
                      31'($urandom_range(0, 30)), 16'($urandom));
        send_word(OP_SERVICE, 32'hFFFF_FFFF, 16'($urandom), 12'($urandom), 1'($urandom),
                  31'($urandom), 16'($urandom));
    endtask

    task automatic random_word();
        int       pick;
        logic [31:0] now;
        pick = $urandom_range(0, 99);
        now  = ($urandom_range(0, 99) < 4) ? 32'($urandom) : clock_ms;
        if (pick < 40)
            send_word(OP_SCHEDULE, now, pick_owner(), pick_kind(), 1'($urandom),
                      pick_delay(), 16'($urandom));
        else if (pick < 52)
            send_word(OP_CANCEL, now, pick_owner(), pick_kind(),
                      ($urandom_range(0, 2) == 0), 31'($urandom), 16'($urandom));
        else if (pick < 70)
            send_word(OP_QUERY, now, pick_owner(), pick_kind(), 1'($urandom),
                      31'($urandom), 16'($urandom));
        else begin
            clock_ms = clock_ms + $urandom_range(0, 15);
            send_word(OP_SERVICE, clock_ms, 16'($urandom), 12'($urandom), 1'($urandom),
                      31'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        clock_ms = $urandom;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(OP_QUERY,    32'd0, 16'h0000, 12'h000, 1'b0, 31'd0, 16'h0000);
        send_word(OP_SERVICE,  32'd0, 16'h0000, 12'h000, 1'b0, 31'd0, 16'h0000);
        // due time wraps past the top of the counter
        send_word(OP_SCHEDULE, 32'hFFFF_FFF0, 16'hFFFF, 12'hFFF, 1'b1, 31'h7FFF_FFFF,
                  16'hFFFF);
        send_word(OP_SCHEDULE, 32'd5, 16'h0000, 12'h000, 1'b0, 31'd0, 16'h0000);
        send_word(OP_SCHEDULE, 32'd5, 16'h0001, 12'h002, 1'b0, 31'd0, 16'h0003);
        send_word(OP_SCHEDULE, 32'd2, 16'h0001, 12'h007, 1'b1, 31'd3, 16'h00A5);
        send_word(OP_SCHEDULE, 32'd9, 16'h0001, 12'h002, 1'b0, 31'd1, 16'h5A5A);
        send_word(OP_QUERY,    32'd0, 16'hFFFF, 12'hFFF, 1'b0, 31'd0, 16'h0000);
        send_word(OP_QUERY,    32'hFFFF_FFFF, 16'h0001, 12'h003, 1'b1, 31'h7FFF_FFFF,
                  16'hFFFF);
        send_word(OP_CANCEL,   32'd0, 16'hFFFF, 12'hFFE, 1'b0, 31'd0, 16'h0000);
        send_word(OP_CANCEL,   32'd0, 16'hFFFF, 12'hFFF, 1'b0, 31'd0, 16'h0000);
        send_word(OP_QUERY,    32'd0, 16'hFFFF, 12'hFFF, 1'b0, 31'd0, 16'h0000);
        send_word(OP_SERVICE,  32'd4, 16'h0000, 12'h000, 1'b0, 31'd0, 16'h0000);
        send_word(OP_SERVICE,  32'd5, 16'h0000, 12'h000, 1'b0, 31'd0, 16'h0000);
        send_word(OP_CANCEL,   32'd0, 16'h0001, 12'h000, 1'b1, 31'd0, 16'h0000);
        send_word(OP_QUERY,    32'd0, 16'h0001, 12'h002, 1'b0, 31'd0, 16'h0000);
        send_word(OP_CANCEL,   32'd0, 16'h0001, 12'h000, 1'b1, 31'd0, 16'h0000);
        send_word(OP_SERVICE,  32'hFFFF_FFFF, 16'hFFFF, 12'hFFF, 1'b1, 31'h7FFF_FFFF,
                  16'hFFFF);

        gaps_on   = 1'b1;
        words_sent = 0;
        flood_queue();
        while (words_sent < RandomWords) begin
            if (words_sent % 40 == 0) gaps_on = $urandom_range(0, 2) != 0;
            if (words_sent % 120 == 119) flood_queue();
            else random_word();
        end
        start <= 1'b0;

        do @(negedge i_clk); while (words_awaited != 0);
        repeat (Depth + 8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
